FILE: hw/rtl/lkc_pkg.sv
package lkc_pkg;

  // Field widths of one beat.
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned SEED_W  = 32;
  localparam int unsigned STATE_W = 31;
  localparam int unsigned MUL_W   = 15;
  localparam int unsigned PROD_W  = SEED_W + MUL_W;
  localparam int unsigned FOLD_W  = PROD_W - STATE_W;

  // Lehmer generator constants: multiplier and Mersenne prime modulus.
  localparam logic [MUL_W-1:0]   LEHMER_MUL = 15'd16807;
  localparam logic [STATE_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = SEED_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEED = 2'd0,
    CFG_MODE = 2'd1
  } cfg_idx_t;

  // Mode register codes.
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  // One result beat as it is queued for the output side.
  typedef struct packed {
    logic [DATA_W-1:0] result_byte;
    logic              last_out;
  } result_t;

endpackage

FILE: hw/rtl/lkc_keygen.sv
module lkc_keygen
  import lkc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                last,
  input  logic [SEED_W-1:0]   seed,
  output logic [DATA_W-1:0]   key
);

  logic [STATE_W-1:0] gen_state;
  logic               string_start;
  logic [SEED_W-1:0]  prev;
  logic [PROD_W-1:0]  prod;
  logic [SEED_W-1:0]  fold_sum;
  logic [STATE_W-1:0] state_next;

  // A string starts from the seed, otherwise from the stored state.
  assign prev = string_start ? seed : {1'b0, gen_state};

  // Constant multiply, then the Mersenne fold: high bits are added back in.
  assign prod     = PROD_W'(prev) * PROD_W'(LEHMER_MUL);
  assign fold_sum = SEED_W'(prod[STATE_W-1:0]) + SEED_W'(prod[PROD_W-1:STATE_W]);

  // The folded sum stays below twice the modulus, so one subtraction finishes.
  always_comb begin
    if (fold_sum >= SEED_W'(LEHMER_MOD)) begin
      state_next = STATE_W'(fold_sum - SEED_W'(LEHMER_MOD));
    end else begin
      state_next = fold_sum[STATE_W-1:0];
    end
  end

  assign key = state_next[DATA_W-1:0];

  // Generator state advances once per accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state    <= '0;
      string_start <= 1'b1;
    end else if (step) begin
      gen_state    <= state_next;
      string_start <= last;
    end
  end

endmodule

FILE: hw/rtl/lkc_out_queue.sv
module lkc_out_queue
  import lkc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t out_data
);

  result_t    entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  // Two entries let the input side keep going while a result waits.
  assign full      = count[1];
  assign out_valid = (count != 2'd0);
  assign pop       = out_valid && !out_stall;
  assign out_data  = entries[rd_ptr];

  // Storage for queued beats.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: hw/rtl/lehmer_keystream_byte_cipher.sv
// Byte stream cipher with a MINSTD Lehmer keystream (x * 16807 mod 2^31-1).
// Each input beat carries one byte; the generator steps once per byte and
// its low 8 bits are added to the byte (mode 0) or subtracted from it
// (mode 1), modulo 256. The first byte of a string, and the byte after any
// beat with last_in set, restarts the generator from the seed register.
// One byte is accepted every cycle while in_stall is low: the generator
// multiply and fold are combinational, and each result is registered.
// A two-entry output queue absorbs output stalls; in_stall rises only when
// both entries are full. Write seed and mode only while no beat is in flight.
module lehmer_keystream_byte_cipher
  import lkc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration writes
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input beats
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [DATA_W-1:0]     data_byte,
  input  logic                  last_in,
  // Result beats
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [DATA_W-1:0]     result_byte,
  output logic                  last_out
);

  logic [SEED_W-1:0] seed;
  logic              mode;
  logic              accept;
  logic              full;
  logic [DATA_W-1:0] key;
  result_t           res;
  result_t           head;

  // Configuration registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_W'(1);
      mode <= MODE_ENCRYPT;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SEED: seed <= cfg_data;
        CFG_MODE: mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign accept   = in_valid && !full;

  lkc_keygen u_keygen (
    .clk  (clk),
    .rst  (rst),
    .step (accept),
    .last (last_in),
    .seed (seed),
    .key  (key)
  );

  // Combine the byte with its key byte.
  always_comb begin
    if (mode == MODE_DECRYPT) begin
      res.result_byte = data_byte - key;
    end else begin
      res.result_byte = data_byte + key;
    end
    res.last_out = last_in;
  end

  lkc_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (head)
  );

  assign result_byte = head.result_byte;
  assign last_out    = head.last_out;

endmodule
